// File: hdl/shelf_rect_packer_assert.svh
// assertion macros shared by the shelf packer checker
`ifndef SHELF_RECT_PACKER_ASSERT_SVH
`define SHELF_RECT_PACKER_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge outside reset
`define SRP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SRP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/srp_pkg.sv
// types, constants and codes shared by the shelf packer modules
package srp_pkg;

  localparam int PAGE_LIMIT = 16;
  localparam int MAX_EDGE   = 8192;
  localparam int MIN_EDGE   = 4;

  localparam int EDGE_W  = 14;
  localparam int POS_W   = 13;
  localparam int MIP_W   = 4;
  localparam int BYTES_W = 48;
  localparam int PAGE_W  = $clog2(PAGE_LIMIT);
  localparam int CNT_W   = $clog2(PAGE_LIMIT + 1);
  localparam int PB_W    = 2 * EDGE_W + 1;
  localparam int PROD_W  = PB_W + CNT_W;
  localparam int CFG_W   = BYTES_W;

  typedef enum logic [1:0] {
    ST_PLACED    = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_LIMIT     = 2'd2,
    ST_BAD_CFG   = 2'd3
  } srp_status_t;

  typedef enum logic [1:0] {
    CFG_PAGE_SIZE  = 2'd0,
    CFG_MIP_LEVELS = 2'd1,
    CFG_MAX_PAGES  = 2'd2,
    CFG_MAX_BYTES  = 2'd3
  } srp_cfg_idx_t;

  // commands from the controller
  typedef struct packed {
    logic        load;
    logic        prep;
    logic        scan_inc;
    logic        commit;
    logic        new_page;
    logic        emit;
    srp_status_t code;
  } srp_cmd_t;

  // status back to the controller
  typedef struct packed {
    logic cfg_ok;
    logic too_big;
    logic scan_end;
    logic hit;
    logic limit_fail;
  } srp_stat_t;

endpackage

// File: hdl/srp_ctrl.sv
// placement sequencer: check, page scan, new page, result
module srp_ctrl import srp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  srp_stat_t stat,
  output logic      busy,
  output srp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_EVAL,
    S_SCAN,
    S_OPEN
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.code  = ST_PLACED;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.prep  = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (!stat.cfg_ok) begin
          cmd.emit  = 1'b1;
          cmd.code  = ST_BAD_CFG;
          state_nxt = S_IDLE;
        end else if (stat.too_big) begin
          cmd.emit  = 1'b1;
          cmd.code  = ST_TOO_LARGE;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_end) begin
          state_nxt = S_OPEN;
        end else if (stat.hit) begin
          cmd.commit = 1'b1;
          cmd.emit   = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      S_OPEN: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
        if (stat.limit_fail) begin
          cmd.code = ST_LIMIT;
        end else begin
          cmd.commit   = 1'b1;
          cmd.new_page = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    busy_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule

// File: hdl/srp_dpath.sv
// packer datapath: settings, shelf table, fit tests and result register
module srp_dpath import srp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic                in_start_new,
  input  logic [EDGE_W-1:0]   in_rect_width,
  input  logic [EDGE_W-1:0]   in_rect_height,
  input  logic                in_srgb_class,
  input  srp_cmd_t            cmd,
  output srp_stat_t           stat,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [PAGE_W-1:0]   out_page_index,
  output logic [POS_W-1:0]    out_pos_x,
  output logic [POS_W-1:0]    out_pos_y,
  output logic                out_opened_page
);

  // settings
  logic [EDGE_W-1:0]  page_size_r;
  logic [MIP_W-1:0]   mip_levels_r;
  logic [CNT_W-1:0]   max_pages_r;
  logic [BYTES_W-1:0] max_bytes_r;

  // per-page shelf table
  logic [EDGE_W-1:0] shelf_x_r   [PAGE_LIMIT];
  logic [EDGE_W-1:0] shelf_y_r   [PAGE_LIMIT];
  logic [EDGE_W-1:0] shelf_h_r   [PAGE_LIMIT];
  logic              page_cls_r  [PAGE_LIMIT];
  logic [CNT_W-1:0]  pages_open_r;

  // current word and prepared values
  logic [EDGE_W-1:0] w_r, h_r, pad_r, pw_r, ph_r;
  logic              cls_r;
  logic              cfg_ok_r, too_big_r;
  logic [PB_W-1:0]   pbytes_r;
  logic [PROD_W-1:0] prod_r;
  logic [CNT_W-1:0]  idx_r;

  // result register
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [PAGE_W-1:0] out_page_r;
  logic [POS_W-1:0]  out_x_r, out_y_r;
  logic              out_opened_r;

  // settings check
  logic [MIP_W-1:0]  lg;
  logic              ps_ok, mip_ok;
  logic [EDGE_W-1:0] pad;
  logic [15:0]       w2, h2, w_rnd, h_rnd, pad_mask;
  logic [PB_W-1:0]   pbytes;

  always_comb begin
    lg = '0;
    for (int i = 0; i < EDGE_W; i++) begin
      if (page_size_r[i]) lg = MIP_W'(i);
    end
  end

  assign ps_ok = (page_size_r != '0)
              && ((page_size_r & (page_size_r - 1'b1)) == '0)
              && (page_size_r >= EDGE_W'(MIN_EDGE))
              && (page_size_r <= EDGE_W'(MAX_EDGE));
  assign mip_ok = (mip_levels_r != '0)
               && ({1'b0, mip_levels_r} <= ({1'b0, lg} + 5'd1));

  // one mip level of edge e costs 4*e*e bytes: one bit per level
  always_comb begin
    pbytes = '0;
    for (int j = 0; j < EDGE_W; j++) begin
      if ((5'(j) <= {1'b0, lg}) && ((5'(j) + {1'b0, mip_levels_r}) >= ({1'b0, lg} + 5'd1)))
        pbytes[2*j+2] = 1'b1;
    end
  end

  assign pad      = EDGE_W'(15'd1 << (mip_levels_r - 4'd1));
  assign w2       = 16'(w_r) + {1'b0, pad, 1'b0};
  assign h2       = 16'(h_r) + {1'b0, pad, 1'b0};
  assign pad_mask = ~(16'(pad) - 16'd1);
  assign w_rnd    = (w2 + 16'(pad) - 16'd1) & pad_mask;
  assign h_rnd    = (h2 + 16'(pad) - 16'd1) & pad_mask;

  // candidate position on the page under scan
  logic [PAGE_W-1:0] sel;
  logic [EDGE_W-1:0] sx, sy, sh;
  logic              wrap, fits;
  logic [EDGE_W-1:0] cand_x;
  logic [EDGE_W:0]   cand_y;

  assign sel    = idx_r[PAGE_W-1:0];
  assign sx     = shelf_x_r[sel];
  assign sy     = shelf_y_r[sel];
  assign sh     = shelf_h_r[sel];
  assign wrap   = (15'(sx) + 15'(pw_r)) > 15'(page_size_r);
  assign cand_x = wrap ? '0 : sx;
  assign cand_y = wrap ? (15'(sy) + 15'(sh)) : 15'(sy);
  assign fits   = (16'(cand_y) + 16'(ph_r)) <= 16'(page_size_r);

  // page cap and byte budget
  logic [CNT_W-1:0] cap;
  assign cap = (max_pages_r > CNT_W'(PAGE_LIMIT)) ? CNT_W'(PAGE_LIMIT) : max_pages_r;

  assign stat.cfg_ok     = cfg_ok_r;
  assign stat.too_big    = too_big_r;
  assign stat.scan_end   = (idx_r >= pages_open_r);
  assign stat.hit        = (page_cls_r[sel] == cls_r) && fits;
  assign stat.limit_fail = (pages_open_r >= cap) || (BYTES_W'(prod_r) > max_bytes_r);

  // commit values
  logic [PAGE_W-1:0] cm_page;
  logic [EDGE_W-1:0] cm_x, cm_h;
  logic [EDGE_W:0]   cm_y;

  assign cm_page = cmd.new_page ? pages_open_r[PAGE_W-1:0] : sel;
  assign cm_x    = cmd.new_page ? '0 : cand_x;
  assign cm_y    = cmd.new_page ? '0 : cand_y;
  always_comb begin
    if (cmd.new_page || (cand_y != 15'(sy)))
      cm_h = ph_r;
    else
      cm_h = (sh > ph_r) ? sh : ph_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_size_r  <= EDGE_W'(1024);
      mip_levels_r <= MIP_W'(1);
      max_pages_r  <= CNT_W'(PAGE_LIMIT);
      max_bytes_r  <= '1;
      pages_open_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PAGE_SIZE:  page_size_r  <= cfg_data[EDGE_W-1:0];
          CFG_MIP_LEVELS: mip_levels_r <= cfg_data[MIP_W-1:0];
          CFG_MAX_PAGES:  max_pages_r  <= cfg_data[CNT_W-1:0];
          CFG_MAX_BYTES:  max_bytes_r  <= cfg_data[BYTES_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load && in_start_new)
        pages_open_r <= '0;
      else if (cmd.commit && cmd.new_page)
        pages_open_r <= pages_open_r + 1'b1;
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w_r   <= in_rect_width;
      h_r   <= in_rect_height;
      cls_r <= in_srgb_class;
    end
    if (cmd.prep) begin
      cfg_ok_r  <= ps_ok && mip_ok && (max_pages_r != '0);
      too_big_r <= (w2 > 16'(page_size_r)) || (h2 > 16'(page_size_r));
      pad_r     <= pad;
      pw_r      <= EDGE_W'(w_rnd);
      ph_r      <= EDGE_W'(h_rnd);
      pbytes_r  <= pbytes;
      idx_r     <= '0;
    end else if (cmd.scan_inc) begin
      idx_r <= idx_r + 1'b1;
    end
    // bytes needed with one more page, ready before any new-page decision
    prod_r <= PROD_W'(pages_open_r + 1'b1) * PROD_W'(pbytes_r);
    if (cmd.commit) begin
      shelf_x_r[cm_page]  <= EDGE_W'(15'(cm_x) + 15'(pw_r));
      shelf_y_r[cm_page]  <= cm_y[EDGE_W-1:0];
      shelf_h_r[cm_page]  <= cm_h;
      page_cls_r[cm_page] <= cls_r;
    end
    if (cmd.emit) begin
      out_status_r <= cmd.code;
      if (cmd.commit) begin
        out_page_r   <= cm_page;
        out_x_r      <= POS_W'(15'(cm_x) + 15'(pad_r));
        out_y_r      <= POS_W'(16'(cm_y) + 16'(pad_r));
        out_opened_r <= cmd.new_page;
      end else begin
        out_page_r   <= '0;
        out_x_r      <= '0;
        out_y_r      <= '0;
        out_opened_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_page_index  = out_page_r;
  assign out_pos_x       = out_x_r;
  assign out_pos_y       = out_y_r;
  assign out_opened_page = out_opened_r;

endmodule

// File: hdl/shelf_rect_packer.sv
// shelf_rect_packer: places rectangles into square pages, one open shelf per page
//
// input: pulse start with in_start_new, in_rect_width, in_rect_height and
// in_srgb_class valid; the word is taken on the edge where start is high and
// busy is low. busy stays high until the result is issued.
// output: one word per input, shown for exactly one cycle with out_valid high
// (status, page index, corner of the unpadded rectangle, opened-page flag).
// the receiver cannot hold results off, and none is needed.
// sequence: the word is loaded and checked, and errors for bad settings or
// oversized rectangles are issued; otherwise the open pages (up to 16) are
// scanned in order for the first of the same class with room; if none has
// room a new page is tried. the page scan reads one shelf entry a cycle.
// a new start may be given in the cycle the result is shown.
// configuration: cfg_we, cfg_index, cfg_data write a register at once; write
// only while the block is idle.
// reset: synchronous, active low; settings return to their defaults and all
// pages are closed. the shelf table itself needs no clearing.
module shelf_rect_packer import srp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_start_new,
  input  logic [EDGE_W-1:0] in_rect_width,
  input  logic [EDGE_W-1:0] in_rect_height,
  input  logic              in_srgb_class,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [PAGE_W-1:0] out_page_index,
  output logic [POS_W-1:0]  out_pos_x,
  output logic [POS_W-1:0]  out_pos_y,
  output logic              out_opened_page
);

  srp_cmd_t  cmd;
  srp_stat_t stat;

  srp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  srp_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_start_new    (in_start_new),
    .in_rect_width   (in_rect_width),
    .in_rect_height  (in_rect_height),
    .in_srgb_class   (in_srgb_class),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_page_index  (out_page_index),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_opened_page (out_opened_page)
  );

endmodule

// File: hdl/srp_checker.sv
// port-level checks for the shelf packer, bound to the top level
`include "shelf_rect_packer_assert.svh"

module srp_checker import srp_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [1:0]        out_status,
  input logic [PAGE_W-1:0] out_page_index,
  input logic [POS_W-1:0]  out_pos_x,
  input logic [POS_W-1:0]  out_pos_y,
  input logic              out_opened_page
);

  `SRP_ASSERT_NXT(a_accept_busy, start && !busy, busy, "busy not raised after accepted word")
  `SRP_ASSERT_NXT(a_single_strobe, out_valid, !out_valid, "result strobe longer than one cycle")
  `SRP_ASSERT_IMP(a_result_after_work, out_valid, $past(busy), "result without a word in flight")
  `SRP_ASSERT_IMP(a_error_zero, out_valid && (out_status != ST_PLACED), (out_page_index == '0) && (out_pos_x == '0) && (out_pos_y == '0) && !out_opened_page, "error result with nonzero fields")

endmodule

bind shelf_rect_packer srp_checker u_srp_checker (.*);

// File: bench/tb_top.sv
// testbench for shelf_rect_packer: directed table, then random placements checked by a predictor
module tb_top;
  import srp_pkg::*;

  localparam int     CLK_HALF       = 6;
  localparam int     RAND_ITEMS     = 1750;
  localparam int     DRAIN_CYCLES   = 25;
  localparam longint TIMEOUT_CYCLES = 600000;
  localparam int     DIR_ROWS       = 38;

  typedef struct {
    srp_status_t       status;
    logic [PAGE_W-1:0] page;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic              opened;
  } placement_t;

  // register write, rectangle checked by the predictor, or rectangle with its result typed in
  typedef enum bit [1:0] {ROW_REG, ROW_RECT, ROW_KNOWN} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    srp_cfg_idx_t     reg_idx;
    logic [CFG_W-1:0] reg_val;
    bit               sn;
    int               w;
    int               h;
    bit               cls;
    srp_status_t      st;
    int               pg;
    int               x;
    int               y;
    bit               op;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              in_start_new = 1'b0;
  logic [EDGE_W-1:0] in_rect_width = '0;
  logic [EDGE_W-1:0] in_rect_height = '0;
  logic              in_srgb_class = 1'b0;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              busy;
  logic              out_valid;
  logic [1:0]        out_status;
  logic [PAGE_W-1:0] out_page_index;
  logic [POS_W-1:0]  out_pos_x;
  logic [POS_W-1:0]  out_pos_y;
  logic              out_opened_page;

  shelf_rect_packer dut (.*);

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // register copies and shelf table of the predictor
  logic [EDGE_W-1:0] edge_reg = 14'd1024;
  logic [MIP_W-1:0]  mips_reg = 4'd1;
  logic [CNT_W-1:0]  page_cap_reg = 5'd16;
  logic [CFG_W-1:0]  budget_reg = '1;
  int unsigned       shelf_x_at [PAGE_LIMIT];
  int unsigned       shelf_y_at [PAGE_LIMIT];
  int unsigned       shelf_h_at [PAGE_LIMIT];
  bit                class_of [PAGE_LIMIT];
  int unsigned       pages_open = 0;

  placement_t pending_places [$];
  int errors_seen = 0;
  int rects_sent = 0;
  int reg_writes = 0;
  int status_seen [4];

  dir_row_t directed_rows [DIR_ROWS] = '{
    '{ROW_KNOWN, CFG_PAGE_SIZE, 48'd0, 1, 1, 1, 0, ST_PLACED, 0, 1, 1, 1},
    '{ROW_RECT, CFG_PAGE_SIZE, 48'd0, 0, 1022, 1, 0, ST_PLACED, 0, 0, 0, 0},
    '{ROW_KNOWN, CFG_PAGE_SIZE, 48'd0, 0, 1023, 5, 0, ST_TOO_LARGE, 0, 0, 0, 0},
    '{ROW_KNOWN, CFG_PAGE_SIZE, 48'd0, 0, 16383, 16383, 1, ST_TOO_LARGE, 0, 0, 0, 0},
    '{ROW_RECT, CFG_PAGE_SIZE, 48'd0, 0, 0, 0, 0, ST_PLACED, 0, 0, 0, 0},
    '{ROW_RECT, CFG_PAGE_SIZE, 48'd0, 0, 8, 8, 1, ST_PLACED, 0, 0, 0, 0},
    '{ROW_RECT, CFG_PAGE_SIZE, 48'd0, 0, 1, 1022, 0, ST_PLACED, 0, 0, 0, 0},
    '{ROW_RECT, CFG_PAGE_SIZE, 48'd0, 0, 1022, 1022, 1, ST_PLACED, 0, 0, 0, 0},
    '{ROW_REG, CFG_PAGE_SIZE, 48'd8192, 0, 0, 0, 0, ST_PLACED, 0, 0, 0, 0},
    '{ROW_REG, CFG_MIP_LEVELS, 48'd14, 0, 0, 0, 0, ST_PLACED, 0, 0, 0, 0},
    '{ROW_KNOWN, CFG_PAGE_SIZE, 48'd0, 1, 0, 0, 0, ST_TOO_LARGE, 0, 0, 0, 0},
    '{ROW_REG, CFG_MIP_LEVELS, 48'd13, 0, 0, 0, 0, ST_PLACED, 0, 0, 0, 0},
    '{ROW_KNOWN, CFG_PAGE_SIZE, 48'd0, 0, 0, 0, 1, ST_PLACED, 0, 4096, 4096, 1},
    '{ROW_REG, CFG_MIP_LEVELS, 48'd15, 0, 0, 0, 0, ST_PLACED, 0, 0, 0, 0},
    '{ROW_KNOWN, CFG_PAGE_SIZE, 48'd0, 0, 1, 1, 0, ST_BAD_CFG, 0, 0, 0, 0},
    '{ROW_REG, CFG_MIP_LEVELS, 48'd1, 0, 0, 0, 0, ST_PLACED, 0, 0, 0, 0},
    '{ROW_REG, CFG_MAX_PAGES, 48'd1, 0, 0, 0, 0, ST_PLACED, 0, 0, 0, 0},
    '{ROW_KNOWN, CFG_PAGE_SIZE, 48'd0, 1, 8190, 8190, 0, ST_PLACED, 0, 1, 1, 1},
    '{ROW_KNOWN, CFG_PAGE_SIZE, 48'd0, 0, 1, 1, 1, ST_LIMIT, 0, 0, 0, 0},
    '{ROW_KNOWN, CFG_PAGE_SIZE, 48'd0, 0, 1, 1, 0, ST_LIMIT, 0, 0, 0, 0},
    '{ROW_REG, CFG_MAX_PAGES, 48'd0, 0, 0, 0, 0, ST_PLACED, 0, 0, 0, 0},
    '{ROW_KNOWN, CFG_PAGE_SIZE, 48'd0, 1, 1, 1, 0, ST_BAD_CFG, 0, 0, 0, 0},
    '{ROW_REG, CFG_MAX_PAGES, 48'd31, 0, 0, 0, 0, ST_PLACED, 0, 0, 0, 0},
    '{ROW_REG, CFG_PAGE_SIZE, 48'd4, 0, 0, 0, 0, ST_PLACED, 0, 0, 0, 0},
    '{ROW_REG, CFG_MAX_BYTES, 48'd0, 0, 0, 0, 0, ST_PLACED, 0, 0, 0, 0},
    '{ROW_KNOWN, CFG_PAGE_SIZE, 48'd0, 1, 2, 2, 0, ST_LIMIT, 0, 0, 0, 0},
    '{ROW_REG, CFG_MAX_BYTES, 48'd64, 0, 0, 0, 0, ST_PLACED, 0, 0, 0, 0},
    '{ROW_KNOWN, CFG_PAGE_SIZE, 48'd0, 0, 2, 2, 0, ST_PLACED, 0, 1, 1, 1},
    '{ROW_KNOWN, CFG_PAGE_SIZE, 48'd0, 0, 2, 2, 0, ST_LIMIT, 0, 0, 0, 0},
    '{ROW_REG, CFG_MAX_BYTES, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0, ST_PLACED, 0, 0, 0, 0},
    '{ROW_RECT, CFG_PAGE_SIZE, 48'd0, 0, 2, 2, 1, ST_PLACED, 0, 0, 0, 0},
    '{ROW_RECT, CFG_PAGE_SIZE, 48'd0, 0, 0, 0, 0, ST_PLACED, 0, 0, 0, 0},
    '{ROW_REG, CFG_PAGE_SIZE, 48'd6, 0, 0, 0, 0, ST_PLACED, 0, 0, 0, 0},
    '{ROW_KNOWN, CFG_PAGE_SIZE, 48'd0, 0, 1, 1, 0, ST_BAD_CFG, 0, 0, 0, 0},
    '{ROW_REG, CFG_PAGE_SIZE, 48'd16383, 0, 0, 0, 0, ST_PLACED, 0, 0, 0, 0},
    '{ROW_KNOWN, CFG_PAGE_SIZE, 48'd0, 1, 1, 1, 0, ST_BAD_CFG, 0, 0, 0, 0},
    '{ROW_REG, CFG_PAGE_SIZE, 48'd0, 0, 0, 0, 0, ST_PLACED, 0, 0, 0, 0},
    '{ROW_KNOWN, CFG_PAGE_SIZE, 48'd0, 0, 1, 1, 0, ST_BAD_CFG, 0, 0, 0, 0}
  };

  function automatic placement_t place_rect(bit sn, int unsigned w, int unsigned h, bit cls);
    placement_t      res;
    int unsigned     ps, lg, s, pad, pw, ph, pg, x, y, cap;
    longint unsigned pbytes, allowed, e;
    bit              fresh;
    res.status = ST_PLACED;
    res.page = '0;
    res.pos_x = '0;
    res.pos_y = '0;
    res.opened = 1'b0;
    ps = edge_reg;
    x = 0;
    y = 0;
    fresh = 1'b0;
    pbytes = 0;
    // clearing happens even when the settings turn out bad
    if (sn) begin
      for (int i = 0; i < PAGE_LIMIT; i++) begin
        shelf_x_at[i] = 0;
        shelf_y_at[i] = 0;
        shelf_h_at[i] = 0;
        class_of[i] = 1'b0;
      end
      pages_open = 0;
    end
    lg = 0;
    s = ps;
    while (s > 1) begin
      s >>= 1;
      lg++;
    end
    if (ps < MIN_EDGE || ps > MAX_EDGE || (ps & (ps - 1)) != 0 || mips_reg == 0 ||
        mips_reg > lg + 1 || page_cap_reg == 0) begin
      res.status = ST_BAD_CFG;
      return res;
    end
    pad = 1 << (mips_reg - 1);
    if (w + 2 * pad > ps || h + 2 * pad > ps) begin
      res.status = ST_TOO_LARGE;
      return res;
    end
    pw = (w + 3 * pad - 1) & ~(pad - 1);
    ph = (h + 3 * pad - 1) & ~(pad - 1);
    for (pg = 0; pg < pages_open && pg < PAGE_LIMIT; pg++) begin
      if (class_of[pg] != cls) continue;
      x = shelf_x_at[pg];
      y = shelf_y_at[pg];
      if (x + pw > ps) begin
        x = 0;
        y += shelf_h_at[pg];
      end
      if (y + ph <= ps) break;
    end
    if (pg >= pages_open || pg >= PAGE_LIMIT) begin
      pg = pages_open;
      cap = (page_cap_reg > PAGE_LIMIT) ? PAGE_LIMIT : page_cap_reg;
      // bytes of one page with its configured mip levels, four per texel
      for (int m = 0; m < mips_reg; m++) begin
        e = ps >> m;
        pbytes += e * e * 4;
      end
      allowed = budget_reg / pbytes;
      if (pg >= cap || pg + 64'd1 > allowed) begin
        res.status = ST_LIMIT;
        return res;
      end
      pages_open = pg + 1;
      class_of[pg] = cls;
      shelf_x_at[pg] = 0;
      shelf_y_at[pg] = 0;
      shelf_h_at[pg] = 0;
      x = 0;
      y = 0;
      fresh = 1'b1;
    end
    if (y == shelf_y_at[pg])
      shelf_h_at[pg] = (shelf_h_at[pg] > ph) ? shelf_h_at[pg] : ph;
    else
      shelf_h_at[pg] = ph;
    shelf_x_at[pg] = (x + pw) & 32'h3FFF;
    shelf_y_at[pg] = y & 32'h3FFF;
    res.page = pg[PAGE_W-1:0];
    res.pos_x = POS_W'(x + pad);
    res.pos_y = POS_W'(y + pad);
    res.opened = fresh;
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors_seen++;
    end
  endfunction

  function automatic int rand_gap(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  always @(posedge clk) begin
    placement_t want;
    if (rst_n && out_valid) begin
      if (pending_places.size() == 0) begin
        $error("result word with no placement pending");
        errors_seen++;
      end else begin
        want = pending_places.pop_front();
        check_field("out_status", want.status, out_status);
        check_field("out_page_index", want.page, out_page_index);
        check_field("out_pos_x", want.pos_x, out_pos_x);
        check_field("out_pos_y", want.pos_y, out_pos_y);
        check_field("out_opened_page", want.opened, out_opened_page);
        status_seen[want.status]++;
      end
    end
  end

  // hold the word until the block takes it, then predict and optionally pause
  task automatic send_rect(bit sn, logic [EDGE_W-1:0] w, logic [EDGE_W-1:0] h, bit cls,
                           int gap, bit typed, placement_t want);
    placement_t got_pred;
    in_start_new <= sn;
    in_rect_width <= w;
    in_rect_height <= h;
    in_srgb_class <= cls;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    got_pred = place_rect(sn, w, h, cls);
    pending_places = {pending_places, (typed ? want : got_pred)};
    rects_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (pending_places.size() != 0 || busy);
  endtask

  task automatic write_reg(srp_cfg_idx_t idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_PAGE_SIZE:  edge_reg = val[EDGE_W-1:0];
      CFG_MIP_LEVELS: mips_reg = val[MIP_W-1:0];
      CFG_MAX_PAGES:  page_cap_reg = val[CNT_W-1:0];
      CFG_MAX_BYTES:  budget_reg = val;
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    dir_row_t         row;
    placement_t       want;
    int               n, r, span;
    int unsigned      lg, ps_new, mip_new, cap_new, pad;
    longint unsigned  pb;
    logic [CFG_W-1:0] bytes_new, junk;
    logic [EDGE_W-1:0] w, h;
    bit               sn, cls, burst;

    want.status = ST_PLACED;
    want.page = '0;
    want.pos_x = '0;
    want.pos_y = '0;
    want.opened = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_REG) begin
        settle();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        want.status = row.st;
        want.page = row.pg[PAGE_W-1:0];
        want.pos_x = POS_W'(row.x);
        want.pos_y = POS_W'(row.y);
        want.opened = row.op;
        send_rect(row.sn, EDGE_W'(row.w), EDGE_W'(row.h), row.cls, rand_gap(1'b0),
                  row.kind == ROW_KNOWN, want);
      end
    end

    while (rects_sent < RAND_ITEMS) begin
      settle();
      lg = $urandom_range(0, 1) ? $urandom_range(2, 6) : $urandom_range(2, 13);
      ps_new = 1 << lg;
      if ($urandom_range(0, 11) == 0) ps_new = $urandom_range(0, 16383);
      mip_new = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(1, lg + 1);
      if ($urandom_range(0, 19) == 0) mip_new = $urandom_range(0, 15);
      r = $urandom_range(0, 19);
      cap_new = (r == 0) ? 0 : (r < 5) ? $urandom_range(17, 31) : $urandom_range(1, 16);
      pb = 0;
      for (int m = 0; m < mip_new; m++) pb += longint'(ps_new >> m) * (ps_new >> m) * 4;
      r = $urandom_range(0, 19);
      if (r < 11) bytes_new = '1;
      else if (r < 17) bytes_new = CFG_W'(pb * $urandom_range(0, 17));
      else bytes_new = CFG_W'({$urandom, $urandom});
      // now and then stray bits above the register width, which must be dropped
      junk = ($urandom_range(0, 7) == 0) ? CFG_W'({$urandom, $urandom}) : '0;
      write_reg(CFG_PAGE_SIZE, {junk[CFG_W-1:EDGE_W], EDGE_W'(ps_new)});
      write_reg(CFG_MIP_LEVELS, {junk[CFG_W-1:MIP_W], MIP_W'(mip_new)});
      write_reg(CFG_MAX_PAGES, {junk[CFG_W-1:CNT_W], CNT_W'(cap_new)});
      write_reg(CFG_MAX_BYTES, bytes_new);

      pad = (mips_reg == 0) ? 1 : 1 << (mips_reg - 1);
      span = int'(edge_reg) - 2 * int'(pad);
      n = $urandom_range(40, 120);
      burst = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < n; k++) begin
        r = $urandom_range(0, 99);
        if (r < 8 || span < 0) begin
          w = EDGE_W'($urandom_range(0, 16383));
          h = EDGE_W'($urandom_range(0, 16383));
        end else if (r < 14) begin
          // right at the edge of fitting
          w = EDGE_W'(span + int'($urandom_range(0, 1)));
          h = EDGE_W'($urandom_range(0, span + 1));
        end else if (r < 30) begin
          w = EDGE_W'($urandom_range(0, span));
          h = EDGE_W'($urandom_range(0, span));
        end else begin
          w = EDGE_W'($urandom_range(0, span / 4));
          h = EDGE_W'($urandom_range(0, span / 4));
        end
        cls = 1'($urandom_range(0, 1));
        sn = (k == 0) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 39) == 0);
        if (k > 0 && $urandom_range(0, 49) == 0) settle();
        send_rect(sn, w, h, cls, rand_gap(burst), 1'b0, want);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_places.size() != 0) begin
      $error("%0d placements never came back", pending_places.size());
      errors_seen++;
    end
    $display("covered %0d rectangles with %0d register writes", rects_sent, reg_writes);
    $display("outcomes: %0d placed, %0d too large, %0d at page or byte limit, %0d bad settings",
             status_seen[ST_PLACED], status_seen[ST_TOO_LARGE], status_seen[ST_LIMIT],
             status_seen[ST_BAD_CFG]);
    if (errors_seen == 0)
      $display("shelf_rect_packer test passed");
    else
      $display("shelf_rect_packer test failed");
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("shelf_rect_packer test failed");
    $finish;
  end

endmodule
